// ===== rtl/epipolar_error_evaluator_assert.svh =====
// Assertion macros used by the checker file of the evaluator.
`ifndef EPIPOLAR_ERROR_EVALUATOR_ASSERT_SVH
`define EPIPOLAR_ERROR_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define EEE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define EEE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package eee_pkg;

  // Internal mantissa width of the shared normalize and round stages.
  localparam int MW = 51;
  // Signed exponent width before rounding.
  localparam int EW = 12;

  localparam int LAT_ARITH = 4;
  localparam int DIV_STEPS = 26;
  localparam int LAT_DIV   = DIV_STEPS + 3;

  localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
  localparam logic [31:0] FP_CANON_NAN = 32'h7FC0_0000;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MW0  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MW1  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MW2  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MW3  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MW4  = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV
  } fp_op_t;

  typedef enum logic [1:0] {
    K_FIN,
    K_ZERO,
    K_INF,
    K_NAN
  } fp_kind_t;

  typedef struct packed {
    fp_kind_t    kind;
    logic        sign;
    logic [7:0]  expo;
    logic [23:0] mant;
  } fp_unp_t;

  // Value of a finite item is mant * 2^(base - 127 - (MW - 2)).
  typedef struct packed {
    fp_kind_t              kind;
    logic                  sign;
    logic signed [EW-1:0]  base;
    logic [MW-1:0]         mant;
  } fp_raw_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] x);
    fp_unp_t u;
    u.sign = x[31];
    u.expo = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    u.mant = {(x[30:23] != 8'd0), x[22:0]};
    if (x[30:23] == 8'hFF) begin
      u.kind = (x[22:0] != 23'd0) ? K_NAN : K_INF;
    end else if (x[30:0] == 31'd0) begin
      u.kind = K_ZERO;
    end else begin
      u.kind = K_FIN;
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/epipolar_error_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while out_tready does not stall the
// output; every stage is a register, and the 26-step restoring divider is
// fully unrolled into stages.
// A stall on out_tready freezes the whole pipeline, and in_tready follows it.
// Reset (synchronous, rst_n low) clears the valid bits, the mode and the matrix.
module epipolar_error_evaluator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // first_x [31:0], first_y [63:32], second_x [95:64], second_y [127:96]
  input  wire logic [127:0]               in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // squared_error [31:0]
  output logic [31:0]                     out_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [eee_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [63:0]                cfg_wdata
);

  localparam int L   = eee_pkg::LAT_ARITH;
  localparam int LAT = 9 * L + eee_pkg::LAT_DIV + 1;

  logic        mode_r;
  logic [63:0] mw0_r;
  logic [63:0] mw1_r;
  logic [63:0] mw2_r;
  logic [63:0] mw3_r;
  logic [31:0] mw4_r;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [31:0]    out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      mw0_r  <= 64'd0;
      mw1_r  <= 64'd0;
      mw2_r  <= 64'd0;
      mw3_r  <= 64'd0;
      mw4_r  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        eee_pkg::REG_MODE: mode_r <= cfg_wdata[0];
        eee_pkg::REG_MW0:  mw0_r  <= cfg_wdata;
        eee_pkg::REG_MW1:  mw1_r  <= cfg_wdata;
        eee_pkg::REG_MW2:  mw2_r  <= cfg_wdata;
        eee_pkg::REG_MW3:  mw3_r  <= cfg_wdata;
        eee_pkg::REG_MW4:  mw4_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] f00, f01, f02, f10, f11, f12, f20, f21, f22;
  logic [31:0] x1, y1, x2, y2;

  assign f00 = mw0_r[63:32];
  assign f01 = mw0_r[31:0];
  assign f02 = mw1_r[63:32];
  assign f10 = mw1_r[31:0];
  assign f11 = mw2_r[63:32];
  assign f12 = mw2_r[31:0];
  assign f20 = mw3_r[63:32];
  assign f21 = mw3_r[31:0];
  assign f22 = mw4_r;

  assign x1 = in_tdata[31:0];
  assign y1 = in_tdata[63:32];
  assign x2 = in_tdata[95:64];
  assign y2 = in_tdata[127:96];

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Products of the matrix with both points.
  logic [31:0] m1_a [10];
  logic [31:0] m1_b [10];
  logic [31:0] p1   [10];

  assign m1_a[0] = f00;  assign m1_b[0] = x1;
  assign m1_a[1] = f01;  assign m1_b[1] = y1;
  assign m1_a[2] = f10;  assign m1_b[2] = x1;
  assign m1_a[3] = f11;  assign m1_b[3] = y1;
  assign m1_a[4] = f20;  assign m1_b[4] = x1;
  assign m1_a[5] = f21;  assign m1_b[5] = y1;
  assign m1_a[6] = f00;  assign m1_b[6] = x2;
  assign m1_a[7] = f10;  assign m1_b[7] = y2;
  assign m1_a[8] = f01;  assign m1_b[8] = x2;
  assign m1_a[9] = f11;  assign m1_b[9] = y2;

  for (genvar i = 0; i < 10; i++) begin : g_m1
    eee_fpop #(.OP(eee_pkg::OP_MUL)) u_mul (
      .clk(clk), .en(en), .a(m1_a[i]), .b(m1_b[i]), .y(p1[i])
    );
  end

  // Lines a0, a1, a2 and b0, b1.
  logic [31:0] s2  [5];
  logic [31:0] c3  [5];
  logic [31:0] ln  [5];

  assign c3[0] = f02;
  assign c3[1] = f12;
  assign c3[2] = f22;
  assign c3[3] = f20;
  assign c3[4] = f21;

  for (genvar i = 0; i < 5; i++) begin : g_ln
    eee_fpop #(.OP(eee_pkg::OP_ADD)) u_sum (
      .clk(clk), .en(en), .a(p1[2*i]), .b(p1[2*i+1]), .y(s2[i])
    );
    eee_fpop #(.OP(eee_pkg::OP_ADD)) u_off (
      .clk(clk), .en(en), .a(s2[i]), .b(c3[i]), .y(ln[i])
    );
  end

  logic [31:0] x2_d, y2_d;

  eee_dly #(.W(32), .N(3 * L)) u_x2_dly (.clk(clk), .en(en), .d(x2), .q(x2_d));
  eee_dly #(.W(32), .N(3 * L)) u_y2_dly (.clk(clk), .en(en), .d(y2), .q(y2_d));

  // Residual terms and squared line normals.
  logic [31:0] m4_a [6];
  logic [31:0] m4_b [6];
  logic [31:0] p4   [6];

  assign m4_a[0] = x2_d;   assign m4_b[0] = ln[0];
  assign m4_a[1] = y2_d;   assign m4_b[1] = ln[1];
  assign m4_a[2] = ln[0];  assign m4_b[2] = ln[0];
  assign m4_a[3] = ln[1];  assign m4_b[3] = ln[1];
  assign m4_a[4] = ln[3];  assign m4_b[4] = ln[3];
  assign m4_a[5] = ln[4];  assign m4_b[5] = ln[4];

  for (genvar i = 0; i < 6; i++) begin : g_m4
    eee_fpop #(.OP(eee_pkg::OP_MUL)) u_mul (
      .clk(clk), .en(en), .a(m4_a[i]), .b(m4_b[i]), .y(p4[i])
    );
  end

  logic [31:0] rpart, da, db, a2_d;

  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_rpart (
    .clk(clk), .en(en), .a(p4[0]), .b(p4[1]), .y(rpart)
  );
  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_da (
    .clk(clk), .en(en), .a(p4[2]), .b(p4[3]), .y(da)
  );
  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_db (
    .clk(clk), .en(en), .a(p4[4]), .b(p4[5]), .y(db)
  );

  eee_dly #(.W(32), .N(2 * L)) u_a2_dly (.clk(clk), .en(en), .d(ln[2]), .q(a2_d));

  logic [31:0] resid, den, rr;

  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_resid (
    .clk(clk), .en(en), .a(rpart), .b(a2_d), .y(resid)
  );
  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_den (
    .clk(clk), .en(en), .a(da), .b(db), .y(den)
  );
  eee_fpop #(.OP(eee_pkg::OP_MUL)) u_rr (
    .clk(clk), .en(en), .a(resid), .b(resid), .y(rr)
  );

  logic [31:0] da_d, db_d, den_d, num_a, dnm_a, qa, qb;

  eee_dly #(.W(32), .N(2 * L)) u_da_dly  (.clk(clk), .en(en), .d(da),  .q(da_d));
  eee_dly #(.W(32), .N(2 * L)) u_db_dly  (.clk(clk), .en(en), .d(db),  .q(db_d));
  eee_dly #(.W(32), .N(L))     u_den_dly (.clk(clk), .en(en), .d(den), .q(den_d));

  // Divider A gives rr/den for the Sampson distance and 1/da otherwise.
  assign num_a = mode_r ? rr : eee_pkg::FP_ONE;
  assign dnm_a = mode_r ? den_d : da_d;

  eee_fpop #(.OP(eee_pkg::OP_DIV)) u_div_a (
    .clk(clk), .en(en), .a(num_a), .b(dnm_a), .y(qa)
  );
  eee_fpop #(.OP(eee_pkg::OP_DIV)) u_div_b (
    .clk(clk), .en(en), .a(eee_pkg::FP_ONE), .b(db_d), .y(qb)
  );

  logic [31:0] rsum, rr_d, qa_d, sym;

  eee_fpop #(.OP(eee_pkg::OP_ADD)) u_rsum (
    .clk(clk), .en(en), .a(qa), .b(qb), .y(rsum)
  );

  eee_dly #(.W(32), .N(eee_pkg::LAT_DIV + L)) u_rr_dly (
    .clk(clk), .en(en), .d(rr), .q(rr_d)
  );
  eee_dly #(.W(32), .N(2 * L)) u_qa_dly (.clk(clk), .en(en), .d(qa), .q(qa_d));

  eee_fpop #(.OP(eee_pkg::OP_MUL)) u_sym (
    .clk(clk), .en(en), .a(rr_d), .b(rsum), .y(sym)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= mode_r ? qa_d : sym;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

// ===== rtl/eee_dly.sv =====
`timescale 1ns / 1ps
`default_nettype none
module eee_dly #(
  parameter int W = 32,
  parameter int N = 4
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule
`default_nettype wire

// ===== rtl/eee_fpop.sv =====
`timescale 1ns / 1ps
`default_nettype none
module eee_fpop #(
  parameter eee_pkg::fp_op_t OP = eee_pkg::OP_MUL
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  eee_pkg::fp_raw_t raw;
  eee_pkg::fp_raw_t nrm_r;
  eee_pkg::fp_raw_t nrm_nxt;
  logic [31:0]      y_r;
  logic [31:0]      y_nxt;

  generate
    if (OP == eee_pkg::OP_MUL) begin : g_mul
      eee_pkg::fp_unp_t ua_r;
      eee_pkg::fp_unp_t ub_r;
      eee_pkg::fp_raw_t raw_r;
      eee_pkg::fp_raw_t raw_nxt;
      logic [47:0]      prod;

      always_ff @(posedge clk) begin
        if (en) begin
          ua_r  <= eee_pkg::fp_unpack(a);
          ub_r  <= eee_pkg::fp_unpack(b);
          raw_r <= raw_nxt;
        end
      end

      assign prod = ua_r.mant * ub_r.mant;

      always_comb begin
        raw_nxt.sign = ua_r.sign ^ ub_r.sign;
        raw_nxt.base = $signed({4'b0, ua_r.expo}) + $signed({4'b0, ub_r.expo}) - 12'sd127;
        raw_nxt.mant = {prod, 3'b0};
        if (ua_r.kind == eee_pkg::K_NAN || ub_r.kind == eee_pkg::K_NAN ||
            (ua_r.kind == eee_pkg::K_INF && ub_r.kind == eee_pkg::K_ZERO) ||
            (ua_r.kind == eee_pkg::K_ZERO && ub_r.kind == eee_pkg::K_INF)) begin
          raw_nxt.kind = eee_pkg::K_NAN;
        end else if (ua_r.kind == eee_pkg::K_INF || ub_r.kind == eee_pkg::K_INF) begin
          raw_nxt.kind = eee_pkg::K_INF;
        end else if (ua_r.kind == eee_pkg::K_ZERO || ub_r.kind == eee_pkg::K_ZERO) begin
          raw_nxt.kind = eee_pkg::K_ZERO;
        end else begin
          raw_nxt.kind = eee_pkg::K_FIN;
        end
      end

      assign raw = raw_r;

    end else if (OP == eee_pkg::OP_ADD) begin : g_add
      eee_pkg::fp_unp_t big_r;
      eee_pkg::fp_unp_t sml_r;
      eee_pkg::fp_unp_t big_nxt;
      eee_pkg::fp_unp_t sml_nxt;
      eee_pkg::fp_kind_t kind_r;
      eee_pkg::fp_kind_t kind_nxt;
      logic [5:0]       dist_r;
      logic [5:0]       dist_nxt;
      logic             zsign_r;
      logic             sub_r;
      eee_pkg::fp_raw_t raw_r;
      eee_pkg::fp_raw_t raw_nxt;

      always_comb begin
        eee_pkg::fp_unp_t ua;
        eee_pkg::fp_unp_t ub;
        logic [7:0]       d8;
        ua = eee_pkg::fp_unpack(a);
        ub = eee_pkg::fp_unpack(b);
        // Order by magnitude so that the aligned operand is never the larger one.
        if (a[30:0] < b[30:0]) begin
          big_nxt = ub;
          sml_nxt = ua;
        end else begin
          big_nxt = ua;
          sml_nxt = ub;
        end
        d8 = big_nxt.expo - sml_nxt.expo;
        dist_nxt = (d8 > 8'd63) ? 6'd63 : d8[5:0];
        if (ua.kind == eee_pkg::K_NAN || ub.kind == eee_pkg::K_NAN ||
            (ua.kind == eee_pkg::K_INF && ub.kind == eee_pkg::K_INF && a[31] != b[31])) begin
          kind_nxt = eee_pkg::K_NAN;
        end else if (ua.kind == eee_pkg::K_INF || ub.kind == eee_pkg::K_INF) begin
          kind_nxt = eee_pkg::K_INF;
        end else begin
          kind_nxt = eee_pkg::K_FIN;
        end
      end

      always_comb begin
        logic [eee_pkg::MW-1:0]   xa;
        logic [2*eee_pkg::MW-1:0] wide;
        logic [eee_pkg::MW-1:0]   yb;
        logic [eee_pkg::MW-1:0]   sum;
        xa   = {1'b0, big_r.mant, 26'b0};
        wide = {1'b0, sml_r.mant, 26'b0, {eee_pkg::MW{1'b0}}} >> dist_r;
        // Bits shifted out are folded into the lowest bit.
        yb   = wide[2*eee_pkg::MW-1:eee_pkg::MW] |
               {{(eee_pkg::MW-1){1'b0}}, (|wide[eee_pkg::MW-1:0])};
        sum  = sub_r ? (xa - yb) : (xa + yb);
        raw_nxt.kind = kind_r;
        raw_nxt.mant = sum;
        raw_nxt.base = $signed({4'b0, big_r.expo});
        // An exact zero sum is negative only when both operands were negative.
        raw_nxt.sign = (sum == '0 && kind_r == eee_pkg::K_FIN) ? zsign_r : big_r.sign;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          big_r   <= big_nxt;
          sml_r   <= sml_nxt;
          kind_r  <= kind_nxt;
          dist_r  <= dist_nxt;
          zsign_r <= a[31] & b[31];
          sub_r   <= a[31] ^ b[31];
          raw_r   <= raw_nxt;
        end
      end

      assign raw = raw_r;

    end else begin : g_div
      localparam int S = eee_pkg::DIV_STEPS;
      logic [25:0]              rem_r  [S+1];
      logic [25:0]              quo_r  [S+1];
      logic [23:0]              dvs_r  [S+1];
      eee_pkg::fp_kind_t        kind_r [S+1];
      logic                     sign_r [S+1];
      logic signed [eee_pkg::EW-1:0] base_r [S+1];
      logic [23:0]              ma_nxt;
      logic [23:0]              mb_nxt;
      logic signed [eee_pkg::EW-1:0] base_nxt;
      eee_pkg::fp_kind_t        kind_nxt;

      always_comb begin
        eee_pkg::fp_unp_t ua;
        eee_pkg::fp_unp_t ub;
        logic [4:0]       lza;
        logic [4:0]       lzb;
        ua = eee_pkg::fp_unpack(a);
        ub = eee_pkg::fp_unpack(b);
        ma_nxt = ua.mant;
        mb_nxt = ub.mant;
        lza = 5'd0;
        lzb = 5'd0;
        // Subnormal mantissas are brought to [1, 2) before the quotient loop.
        for (int k = 4; k >= 0; k--) begin
          if ((ma_nxt >> (24 - (1 << k))) == 24'd0) begin
            ma_nxt = ma_nxt << (1 << k);
            lza    = lza + 5'(1 << k);
          end
          if ((mb_nxt >> (24 - (1 << k))) == 24'd0) begin
            mb_nxt = mb_nxt << (1 << k);
            lzb    = lzb + 5'(1 << k);
          end
        end
        base_nxt = ($signed({4'b0, ua.expo}) - $signed({7'b0, lza})) -
                   ($signed({4'b0, ub.expo}) - $signed({7'b0, lzb})) + 12'sd127;
        if (ua.kind == eee_pkg::K_NAN || ub.kind == eee_pkg::K_NAN ||
            (ua.kind == eee_pkg::K_ZERO && ub.kind == eee_pkg::K_ZERO) ||
            (ua.kind == eee_pkg::K_INF && ub.kind == eee_pkg::K_INF)) begin
          kind_nxt = eee_pkg::K_NAN;
        end else if (ua.kind == eee_pkg::K_INF || ub.kind == eee_pkg::K_ZERO) begin
          kind_nxt = eee_pkg::K_INF;
        end else if (ua.kind == eee_pkg::K_ZERO || ub.kind == eee_pkg::K_INF) begin
          kind_nxt = eee_pkg::K_ZERO;
        end else begin
          kind_nxt = eee_pkg::K_FIN;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[0]  <= {2'b0, ma_nxt};
          quo_r[0]  <= 26'd0;
          dvs_r[0]  <= mb_nxt;
          kind_r[0] <= kind_nxt;
          sign_r[0] <= a[31] ^ b[31];
          base_r[0] <= base_nxt;
        end
      end

      // One restoring step per stage, quotient most significant bit first.
      for (genvar k = 1; k <= S; k++) begin : g_step
        logic        ge;
        logic [25:0] rem_n;
        assign ge    = rem_r[k-1] >= {2'b0, dvs_r[k-1]};
        assign rem_n = ge ? (rem_r[k-1] - {2'b0, dvs_r[k-1]}) : rem_r[k-1];
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k]  <= {rem_n[24:0], 1'b0};
            quo_r[k]  <= {quo_r[k-1][24:0], ge};
            dvs_r[k]  <= dvs_r[k-1];
            kind_r[k] <= kind_r[k-1];
            sign_r[k] <= sign_r[k-1];
            base_r[k] <= base_r[k-1];
          end
        end
      end

      always_comb begin
        raw.kind = kind_r[S];
        raw.sign = sign_r[S];
        raw.base = base_r[S];
        raw.mant = {1'b0, quo_r[S], (rem_r[S] != 26'd0), 23'b0};
      end
    end
  endgenerate

  // Normalize: leading one to the top bit.
  always_comb begin
    logic [eee_pkg::MW-1:0] m;
    logic [5:0]             lz;
    m  = raw.mant;
    lz = 6'd0;
    for (int k = 5; k >= 0; k--) begin
      if ((m >> (eee_pkg::MW - (1 << k))) == '0) begin
        m  = m << (1 << k);
        lz = lz + 6'(1 << k);
      end
    end
    nrm_nxt.kind = raw.kind;
    nrm_nxt.sign = raw.sign;
    nrm_nxt.mant = m;
    nrm_nxt.base = raw.base + 12'sd1 - $signed({6'b0, lz});
  end

  // Round to nearest even, with gradual underflow and overflow to infinity.
  always_comb begin
    logic [30:0]                pk;
    logic                       g;
    logic                       st;
    logic signed [eee_pkg::EW-1:0] sh12;
    logic [5:0]                 shamt;
    logic [eee_pkg::MW+62:0]    wide;
    logic [eee_pkg::MW-1:0]     mm;
    pk    = 31'd0;
    g     = 1'b0;
    st    = 1'b0;
    sh12  = '0;
    shamt = 6'd0;
    wide  = '0;
    mm    = '0;
    y_nxt = {nrm_r.sign, 31'd0};
    case (nrm_r.kind)
      eee_pkg::K_NAN:  y_nxt = eee_pkg::FP_CANON_NAN;
      eee_pkg::K_INF:  y_nxt = {nrm_r.sign, 8'hFF, 23'd0};
      eee_pkg::K_ZERO: y_nxt = {nrm_r.sign, 31'd0};
      default: begin
        if (nrm_r.mant == '0) begin
          y_nxt = {nrm_r.sign, 31'd0};
        end else if (nrm_r.base >= 12'sd255) begin
          y_nxt = {nrm_r.sign, 8'hFF, 23'd0};
        end else begin
          if (nrm_r.base >= 12'sd1) begin
            pk = {nrm_r.base[7:0], nrm_r.mant[49:27]};
            g  = nrm_r.mant[26];
            st = |nrm_r.mant[25:0];
          end else begin
            sh12  = 12'sd1 - nrm_r.base;
            shamt = (sh12 > 12'sd63) ? 6'd63 : sh12[5:0];
            wide  = {nrm_r.mant, 63'd0} >> shamt;
            mm    = wide[eee_pkg::MW+62:63];
            pk    = {8'd0, mm[49:27]};
            g     = mm[26];
            st    = (|mm[25:0]) | (|wide[62:0]);
          end
          y_nxt = {nrm_r.sign, pk + {30'd0, g & (st | pk[0])}};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_r <= nrm_nxt;
      y_r   <= y_nxt;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/eee_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "epipolar_error_evaluator_assert.svh"
module eee_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  logic out_stall;
  logic out_nan;

  assign out_stall = out_tvalid && !out_tready;
  assign out_nan   = out_tdata[30:23] == 8'hFF && out_tdata[22:0] != 23'd0;

  `EEE_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result moved in stall")

  // With nothing waiting at the output the pipeline must be free to advance.
  `EEE_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")

  `EEE_ASSERT_IMP(a_canon_nan, out_tvalid && out_nan, out_tdata == eee_pkg::FP_CANON_NAN, "NaN not canonical")

  // A squared distance is never negative.
  `EEE_ASSERT_IMP(a_sign_clear, out_tvalid, !out_tdata[31], "negative squared error")

endmodule

bind epipolar_error_evaluator eee_chk u_eee_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_epipolar_error_evaluator.sv =====
`timescale 1ns / 1ps
module tb_epipolar_error_evaluator;

  localparam int PIPE_LAT = 66;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [eee_pkg::CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [eee_pkg::CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  // Keeps the block's configuration and the queue of squared errors still owed by it.
  class epi_scoreboard;
    bit          mode;
    bit [31:0]   fm [9];
    bit [31:0]   pending_err [$];
    int          n_fail;

    function new();
      mode = 1'b0;
      foreach (fm[k]) fm[k] = '0;
      n_fail = 0;
    endfunction

    function bit is_nan(bit [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function bit is_inf(bit [31:0] v);
      return v[30:0] == 31'h7F80_0000;
    endfunction

    function bit is_zero(bit [31:0] v);
      return v[30:0] == 0;
    endfunction

    function real to_real(bit [31:0] v);
      real r;
      if (v[30:23] == 8'hFF) return $bitstoreal({v[31], 63'h7FF0_0000_0000_0000});
      if (v[30:23] == 0) begin
        if (v[22:0] == 0) return $bitstoreal({v[31], 63'd0});
        r = real'(v[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        return v[31] ? -r : r;
      end
      return $bitstoreal({v[31], 11'(v[30:23] + 896), v[22:0], 29'd0});
    endfunction

    // Rounds a double to single precision, nearest even, subnormals included.
    function bit [31:0] to_single(real r);
      bit [63:0] d, mant, q, rem, half;
      int fe, sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) begin
        return (d[51:0] != 0) ? eee_pkg::FP_CANON_NAN : {d[63], 31'h7F80_0000};
      end
      if (d[62:52] == 0) return {d[63], 31'd0};
      mant = {11'd0, 1'b1, d[51:0]};
      fe = int'(d[62:52]) - 1023 + 127;
      sh = (fe >= 1) ? 29 : 29 + 1 - fe;
      if (sh > 55) sh = 55;
      q = mant >> sh;
      rem = mant & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (fe < 1) return {d[63], q[30:0]};
      if (q[24]) begin
        q = q >> 1;
        fe = fe + 1;
      end
      if (fe >= 255) return {d[63], 31'h7F80_0000};
      return {d[63], 8'(fe), q[22:0]};
    endfunction

    function bit [31:0] fmul(bit [31:0] a, bit [31:0] b);
      if (is_nan(a) || is_nan(b)) return eee_pkg::FP_CANON_NAN;
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return eee_pkg::FP_CANON_NAN;
      return to_single(to_real(a) * to_real(b));
    endfunction

    function bit [31:0] fadd(bit [31:0] a, bit [31:0] b);
      if (is_nan(a) || is_nan(b)) return eee_pkg::FP_CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return eee_pkg::FP_CANON_NAN;
      return to_single(to_real(a) + to_real(b));
    endfunction

    function bit [31:0] fdiv(bit [31:0] n, bit [31:0] d);
      if (is_nan(n) || is_nan(d)) return eee_pkg::FP_CANON_NAN;
      if (is_zero(d)) begin
        return is_zero(n) ? eee_pkg::FP_CANON_NAN : {n[31] ^ d[31], 31'h7F80_0000};
      end
      if (is_inf(n) && is_inf(d)) return eee_pkg::FP_CANON_NAN;
      return to_single(to_real(n) / to_real(d));
    endfunction

    function void write_reg(logic [eee_pkg::CFG_AW-1:0] idx, bit [63:0] val);
      case (idx)
        eee_pkg::REG_MODE: mode = val[0];
        eee_pkg::REG_MW0: begin fm[0] = val[63:32]; fm[1] = val[31:0]; end
        eee_pkg::REG_MW1: begin fm[2] = val[63:32]; fm[3] = val[31:0]; end
        eee_pkg::REG_MW2: begin fm[4] = val[63:32]; fm[5] = val[31:0]; end
        eee_pkg::REG_MW3: begin fm[6] = val[63:32]; fm[7] = val[31:0]; end
        eee_pkg::REG_MW4: fm[8] = val[31:0];
        default: ;
      endcase
    endfunction

    function void note_input(bit [127:0] data);
      bit [31:0] x1, y1, x2, y2, a[3], b0, b1, r, rr, da, db, res;
      x1 = data[31:0];
      y1 = data[63:32];
      x2 = data[95:64];
      y2 = data[127:96];
      for (int i = 0; i < 3; i++)
        a[i] = fadd(fadd(fmul(fm[3*i], x1), fmul(fm[3*i+1], y1)), fm[3*i+2]);
      b0 = fadd(fadd(fmul(fm[0], x2), fmul(fm[3], y2)), fm[6]);
      b1 = fadd(fadd(fmul(fm[1], x2), fmul(fm[4], y2)), fm[7]);
      r = fadd(fadd(fmul(x2, a[0]), fmul(y2, a[1])), a[2]);
      rr = fmul(r, r);
      da = fadd(fmul(a[0], a[0]), fmul(a[1], a[1]));
      db = fadd(fmul(b0, b0), fmul(b1, b1));
      if (!mode) begin
        res = fmul(rr, fadd(fdiv(eee_pkg::FP_ONE, da), fdiv(eee_pkg::FP_ONE, db)));
      end else begin
        res = fdiv(rr, fadd(da, db));
      end
      if (is_nan(res)) res = eee_pkg::FP_CANON_NAN;
      pending_err = {pending_err, res};
    endfunction

    function void check_result(bit [31:0] got);
      bit [31:0] want;
      if (pending_err.size() == 0) begin
        $error("squared_error: unexpected result %h", got);
        n_fail++;
        return;
      end
      want = pending_err.pop_front();
      if (got !== want) begin
        $error("squared_error: expected %h, actual %h", want, got);
        n_fail++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [eee_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  epi_scoreboard sb = new();
  int stall_left = 0;
  bit smooth = 1'b0;

  epipolar_error_evaluator dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (smooth) begin
      out_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_tready <= 1'b1;
        [70:95]: begin out_tready <= 1'b0; stall_left <= $urandom_range(0, 3); end
        default: begin out_tready <= 1'b0; stall_left <= $urandom_range(10, 60); end
      endcase
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (smooth || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_point(bit [31:0] x1, bit [31:0] y1, bit [31:0] x2, bit [31:0] y2);
    int g;
    in_tvalid <= 1'b1;
    in_tdata <= {y2, x2, y1, x1};
    do @(posedge clk); while (!in_tready);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Dropping cfg_we again after each write keeps back-to-back writes apart.
  task automatic write_cfg(logic [eee_pkg::CFG_AW-1:0] idx, logic [63:0] val);
    in_tvalid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits on the clock first so that the last accepted transaction is already queued.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_err.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic bit [31:0] coord();
    return sb.to_single((real'($urandom_range(0, 4000000)) - 2000000.0) / 1000.0);
  endfunction

  function automatic bit [31:0] odd_val();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0001;
      5: return 32'h0000_0001;
      6: return 32'h807F_FFFF;
      7: return 32'h7F7F_FFFF;
      8: return 32'h0080_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic bit [31:0] any_val();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return coord();
    if (p < 92) return $urandom;
    return odd_val();
  endfunction

  function automatic bit [31:0] entry_val();
    real scale;
    scale = (real'($urandom_range(1, 1000))) / 1000.0;
    if ($urandom_range(0, 1)) scale = scale / 1000.0;
    return sb.to_single((real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0 * scale);
  endfunction

  task automatic load_matrix(int style);
    logic [63:0] w [5];
    foreach (w[k]) begin
      case (style)
        0: w[k] = {entry_val(), entry_val()};
        1: w[k] = {$urandom, $urandom};
        2: w[k] = '1;
        default: w[k] = '0;
      endcase
    end
    write_cfg(eee_pkg::REG_MW0, w[0]);
    write_cfg(eee_pkg::REG_MW1, w[1]);
    write_cfg(eee_pkg::REG_MW2, w[2]);
    write_cfg(eee_pkg::REG_MW3, w[3]);
    write_cfg(eee_pkg::REG_MW4, w[4]);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset matrix is all zero: both line norms vanish, so the outputs are NaN.
    send_point(coord(), coord(), coord(), coord());
    send_point(32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    write_cfg(eee_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(coord(), coord(), coord(), coord());
    drain();

    // A translation-only matrix: both line norms are one, while the residual is not always zero.
    write_cfg(eee_pkg::REG_MW1, {32'h3F80_0000, 32'h0});
    write_cfg(eee_pkg::REG_MW3, {32'h0, 32'hBF80_0000});
    send_point(32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h3F80_0000, 32'h4000_0000, 32'h0, 32'h0);
    drain();
    write_cfg(eee_pkg::REG_MODE, 64'h0);
    send_point(32'h3F80_0000, 32'h4000_0000, 32'h0, 32'h0);
    send_point(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'hC000_0000);
    drain();

    load_matrix(0);
    write_cfg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_SPARE_HI, 64'h1);
    send_point(32'h7F80_0000, 32'h0, 32'h0, 32'h0);
    send_point(32'hFF80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_point(32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_point(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
    send_point(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h8080_0000);
    send_point(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h4000_0000, 32'h4080_0000, 32'h4100_0000, 32'h4180_0000);
    drain();
    write_cfg(eee_pkg::REG_MODE, 64'h1);
    send_point(32'h7F80_0000, 32'h0, 32'h0, 32'h0);
    send_point(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h8080_0000);
    send_point(32'h4000_0000, 32'h4080_0000, 32'h4100_0000, 32'h4180_0000);
    drain();
    load_matrix(2);
    send_point(coord(), coord(), coord(), coord());
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(eee_pkg::REG_MODE, {$urandom, $urandom});
      load_matrix((ph == 3) ? 1 : (ph == 6) ? 3 : 0);
      smooth = (ph % 4 == 1);
      for (int n = 0; n < 64; n++) send_point(any_val(), any_val(), any_val(), any_val());
      smooth = 1'b0;
      drain();
    end

    if (sb.n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
